// File: rtl/pidfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_pkg
// Types, widths, coefficient defaults and helpers for the PID controller with
// filtered derivative and back-calculation anti-windup.
// ----------------------------------------------------------------------------
package pidfd_pkg;

    localparam int IN_W      = 32;
    localparam int DIF_W     = IN_W + 1;
    localparam int COEF_W    = 32;
    localparam int SPW_W     = 25;
    localparam int POLE_W    = 24;
    localparam int AWG_W     = 31;
    localparam int CFG_W     = 32;
    localparam int REG_IDX_W = 3;

    localparam int Q_FRAC  = 24;
    localparam int MA_W    = 28;
    localparam int MB_W    = 33;
    localparam int OPA_W   = MA_W + Q_FRAC;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = 60;
    localparam int ST_W    = 48;
    localparam int ERR_W   = 35;
    localparam int DEL_W   = 36;
    localparam int TOT_W   = 50;
    localparam int LT_W    = TOT_W + 1;

    localparam int unsigned DERIV_SP_WEIGHT_DEF = 0;

    localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
    localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN,
        REG_SP_WEIGHT,
        REG_DERIV_POLE,
        REG_DERIV_GAIN,
        REG_INTEG_GAIN,
        REG_AW_GAIN,
        REG_OUT_MIN,
        REG_OUT_MAX
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] prop_gain;
        logic        [SPW_W-1:0]  setpoint_weight;
        logic        [POLE_W-1:0] deriv_pole;
        logic signed [COEF_W-1:0] deriv_gain;
        logic signed [COEF_W-1:0] integ_gain;
        logic        [AWG_W-1:0]  antiwindup_gain;
        logic signed [IN_W-1:0]   out_min;
        logic signed [IN_W-1:0]   out_max;
    } t_coef;

    localparam t_coef COEF_RESET = '{
        prop_gain:       32'sh0100_0000,
        setpoint_weight: 25'h100_0000,
        deriv_pole:      24'h00_0000,
        deriv_gain:      32'sh0000_0000,
        integ_gain:      32'sh0000_0000,
        antiwindup_gain: 31'h0000_0000,
        out_min:         32'sh8000_0000,
        out_max:         32'sh7fff_ffff
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_SPD_LO,
        S_SPD_HI,
        S_LD_LO,
        S_LD_HI,
        S_DEL_LO,
        S_DEL_HI,
        S_SP_LO,
        S_SP_HI,
        S_ERR_WAIT,
        S_ERR_LO,
        S_ERR_HI,
        S_SPV_LO,
        S_SPV_HI,
        S_LT_WAIT,
        S_LT_LO,
        S_LT_HI,
        S_INT_ST,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OPA_SP,
        OPA_SPD,
        OPA_SPV,
        OPA_LD,
        OPA_DEL,
        OPA_ERR,
        OPA_LT
    } t_opa_sel;

    typedef enum logic [2:0] {
        OPB_W,
        OPB_DW,
        OPB_POLE,
        OPB_KD,
        OPB_KP,
        OPB_KI,
        OPB_KAW
    } t_opb_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_INIT
    } t_acc_mode;

    typedef enum logic [2:0] {
        INIT_ZERO,
        INIT_PVD,
        INIT_NPV,
        INIT_TI,
        INIT_INTEG
    } t_acc_init;

    typedef struct packed {
        logic      load;
        logic      out_load;
        t_opa_sel  a_sel;
        logic      a_hi;
        t_opb_sel  b_sel;
        logic      neg;
        t_acc_mode acc_mode;
        t_acc_init acc_init;
        logic      st_delta;
        logic      st_deriv;
        logic      st_err;
        logic      st_total;
        logic      st_integ;
        logic      lim_en;
        logic      lt_en;
    } t_ctl;

    function automatic logic signed [ST_W-1:0] f_sat_st(input logic signed [ACC_W-1:0] x);
        logic v_fits;
        v_fits = (&x[ACC_W-1:ST_W-1]) || !(|x[ACC_W-1:ST_W-1]);
        if (v_fits) begin
            return x[ST_W-1:0];
        end else if (x[ACC_W-1]) begin
            return ST_MIN;
        end else begin
            return ST_MAX;
        end
    endfunction

endpackage

// File: rtl/pidfd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_in_if
// Sample request channel: setpoint and measurement.
// ----------------------------------------------------------------------------
interface pidfd_in_if;
    import pidfd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] setpoint;
    logic signed [IN_W-1:0] measurement;

    modport source (output valid, setpoint, measurement, input ready);
    modport sink   (input valid, setpoint, measurement, output ready);
endinterface

// File: rtl/pidfd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_out_if
// Result channel: clamped drive and limit flag.
// ----------------------------------------------------------------------------
interface pidfd_out_if;
    import pidfd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] drive;
    logic                   limited;

    modport source (output valid, drive, limited, input ready);
    modport sink   (input valid, drive, limited, output ready);
endinterface

// File: rtl/pidfd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pidfd_cfg_if;
    import pidfd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pidfd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_regs
// Coefficient and limit register file written through the config channel.
// ----------------------------------------------------------------------------
module pidfd_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [pidfd_pkg::REG_IDX_W-1:0] i_index,
    input  logic [pidfd_pkg::CFG_W-1:0]     i_data,
    output logic                            o_ready,
    output pidfd_pkg::t_coef                o_coef
);
    import pidfd_pkg::*;

    t_coef r_coef;

    assign o_ready = 1'b1;
    assign o_coef  = r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_valid) begin
            case (t_reg_idx'(i_index))
                REG_PROP_GAIN:  r_coef.prop_gain       <= i_data;
                REG_SP_WEIGHT:  r_coef.setpoint_weight <= i_data[SPW_W-1:0];
                REG_DERIV_POLE: r_coef.deriv_pole      <= i_data[POLE_W-1:0];
                REG_DERIV_GAIN: r_coef.deriv_gain      <= i_data;
                REG_INTEG_GAIN: r_coef.integ_gain      <= i_data;
                REG_AW_GAIN:    r_coef.antiwindup_gain <= i_data[AWG_W-1:0];
                REG_OUT_MIN:    r_coef.out_min         <= i_data;
                REG_OUT_MAX:    r_coef.out_max         <= i_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/pidfd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_seq
// Sequencer issuing one partial product per step to the shared multiply
// accumulate unit and steering stores, clamp and result load.
// ----------------------------------------------------------------------------
module pidfd_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    output logic            o_in_ready,
    output pidfd_pkg::t_ctl o_ctl
);
    import pidfd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = (r_state == S_IDLE) || ((r_state == S_OUT) && i_out_free);
        o_ctl.load     = o_in_ready && i_in_valid;
        o_ctl.out_load = 1'b0;
        o_ctl.a_sel    = OPA_SP;
        o_ctl.a_hi     = 1'b0;
        o_ctl.b_sel    = OPB_W;
        o_ctl.neg      = 1'b0;
        o_ctl.acc_mode = ACC_HOLD;
        o_ctl.acc_init = INIT_ZERO;
        o_ctl.st_delta = 1'b0;
        o_ctl.st_deriv = 1'b0;
        o_ctl.st_err   = 1'b0;
        o_ctl.st_total = 1'b0;
        o_ctl.st_integ = 1'b0;
        o_ctl.lim_en   = 1'b0;
        o_ctl.lt_en    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (o_ctl.load) begin
                    n_state = S_SPD_LO;
                end
            end
            // delta = (pv - last pv) - weighted setpoint change
            S_SPD_LO: begin
                o_ctl.a_sel = OPA_SPD;
                o_ctl.b_sel = OPB_DW;
                o_ctl.neg   = 1'b1;
                n_state     = S_SPD_HI;
            end
            S_SPD_HI: begin
                o_ctl.a_sel    = OPA_SPD;
                o_ctl.a_hi     = 1'b1;
                o_ctl.b_sel    = OPB_DW;
                o_ctl.neg      = 1'b1;
                o_ctl.acc_mode = ACC_INIT;
                o_ctl.acc_init = INIT_PVD;
                n_state        = S_LD_LO;
            end
            // filtered derivative
            S_LD_LO: begin
                o_ctl.a_sel    = OPA_LD;
                o_ctl.b_sel    = OPB_POLE;
                o_ctl.acc_mode = ACC_ADD;
                o_ctl.st_delta = 1'b1;
                n_state        = S_LD_HI;
            end
            S_LD_HI: begin
                o_ctl.a_sel    = OPA_LD;
                o_ctl.a_hi     = 1'b1;
                o_ctl.b_sel    = OPB_POLE;
                o_ctl.acc_mode = ACC_INIT;
                o_ctl.acc_init = INIT_ZERO;
                n_state        = S_DEL_LO;
            end
            S_DEL_LO: begin
                o_ctl.a_sel    = OPA_DEL;
                o_ctl.b_sel    = OPB_KD;
                o_ctl.neg      = 1'b1;
                o_ctl.acc_mode = ACC_ADD;
                n_state        = S_DEL_HI;
            end
            S_DEL_HI: begin
                o_ctl.a_sel    = OPA_DEL;
                o_ctl.a_hi     = 1'b1;
                o_ctl.b_sel    = OPB_KD;
                o_ctl.neg      = 1'b1;
                o_ctl.acc_mode = ACC_ADD;
                n_state        = S_SP_LO;
            end
            // weighted error
            S_SP_LO: begin
                o_ctl.a_sel    = OPA_SP;
                o_ctl.b_sel    = OPB_W;
                o_ctl.acc_mode = ACC_ADD;
                o_ctl.st_deriv = 1'b1;
                n_state        = S_SP_HI;
            end
            S_SP_HI: begin
                o_ctl.a_sel    = OPA_SP;
                o_ctl.a_hi     = 1'b1;
                o_ctl.b_sel    = OPB_W;
                o_ctl.acc_mode = ACC_INIT;
                o_ctl.acc_init = INIT_NPV;
                n_state        = S_ERR_WAIT;
            end
            S_ERR_WAIT: begin
                o_ctl.acc_mode = ACC_ADD;
                o_ctl.st_err   = 1'b1;
                n_state        = S_ERR_LO;
            end
            // total = prop + deriv + integral
            S_ERR_LO: begin
                o_ctl.a_sel = OPA_ERR;
                o_ctl.b_sel = OPB_KP;
                n_state     = S_ERR_HI;
            end
            S_ERR_HI: begin
                o_ctl.a_sel    = OPA_ERR;
                o_ctl.a_hi     = 1'b1;
                o_ctl.b_sel    = OPB_KP;
                o_ctl.acc_mode = ACC_INIT;
                o_ctl.acc_init = INIT_TI;
                n_state        = S_SPV_LO;
            end
            // integrator update
            S_SPV_LO: begin
                o_ctl.a_sel    = OPA_SPV;
                o_ctl.b_sel    = OPB_KI;
                o_ctl.acc_mode = ACC_ADD;
                o_ctl.st_total = 1'b1;
                n_state        = S_SPV_HI;
            end
            S_SPV_HI: begin
                o_ctl.a_sel    = OPA_SPV;
                o_ctl.a_hi     = 1'b1;
                o_ctl.b_sel    = OPB_KI;
                o_ctl.acc_mode = ACC_INIT;
                o_ctl.acc_init = INIT_INTEG;
                o_ctl.lim_en   = 1'b1;
                n_state        = S_LT_WAIT;
            end
            S_LT_WAIT: begin
                o_ctl.acc_mode = ACC_ADD;
                o_ctl.lt_en    = 1'b1;
                n_state        = S_LT_LO;
            end
            S_LT_LO: begin
                o_ctl.a_sel = OPA_LT;
                o_ctl.b_sel = OPB_KAW;
                n_state     = S_LT_HI;
            end
            S_LT_HI: begin
                o_ctl.a_sel    = OPA_LT;
                o_ctl.a_hi     = 1'b1;
                o_ctl.b_sel    = OPB_KAW;
                o_ctl.acc_mode = ACC_ADD;
                n_state        = S_INT_ST;
            end
            S_INT_ST: begin
                o_ctl.acc_mode = ACC_ADD;
                o_ctl.st_integ = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = o_ctl.load ? S_SPD_LO : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_SPD_LO))
        else $error("accepted request did not start the sequence");

    a_ready_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> ((r_state == S_IDLE) || (r_state == S_OUT)))
        else $error("ready raised while a request is in progress");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !i_out_free) |=> (r_state == S_OUT))
        else $error("result step left while output slot busy");

endmodule

// File: rtl/pidfd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_dp
// Shared 28x33 multiplier with accumulator, controller state, clamp and
// result register.
// ----------------------------------------------------------------------------
module pidfd_dp #(
    parameter int unsigned DERIV_SP_WEIGHT = pidfd_pkg::DERIV_SP_WEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pidfd_pkg::t_ctl                    i_ctl,
    input  pidfd_pkg::t_coef                   i_coef,
    input  logic signed [pidfd_pkg::IN_W-1:0]  i_setpoint,
    input  logic signed [pidfd_pkg::IN_W-1:0]  i_measurement,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [pidfd_pkg::IN_W-1:0]  o_drive,
    output logic                               o_limited
);
    import pidfd_pkg::*;

    localparam logic signed [MB_W-1:0] DW_B = MB_W'(DERIV_SP_WEIGHT);

    logic signed [IN_W-1:0]   r_sp;
    logic signed [IN_W-1:0]   r_ls;
    logic signed [IN_W-1:0]   r_lm;
    logic signed [DIF_W-1:0]  r_spd;
    logic signed [DIF_W-1:0]  r_spv;
    logic signed [DIF_W-1:0]  r_pvd;
    logic signed [DIF_W-1:0]  r_npv;
    logic signed [ST_W-1:0]   r_integral;
    logic signed [ST_W-1:0]   r_last_deriv;
    logic signed [ST_W:0]     r_ti;
    logic signed [DEL_W-1:0]  r_delta;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [TOT_W-1:0]  r_total;
    logic signed [LT_W-1:0]   r_lt;
    logic signed [IN_W-1:0]   r_lim;
    logic                     r_limited;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_hi;
    logic                     r_prod_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [IN_W-1:0]   r_drive;
    logic                     r_out_limited;

    logic signed [OPA_W-1:0]  w_opa;
    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  w_init;
    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [TOT_W-1:0]  w_min;
    logic signed [TOT_W-1:0]  w_max;
    logic signed [TOT_W-1:0]  w_lo;
    logic signed [TOT_W-1:0]  w_lim;

    // operand a: low 24 bits unsigned, or the floor-shifted high part
    always_comb begin
        case (i_ctl.a_sel)
            OPA_SP:  w_opa = OPA_W'(r_sp);
            OPA_SPD: w_opa = OPA_W'(r_spd);
            OPA_SPV: w_opa = OPA_W'(r_spv);
            OPA_LD:  w_opa = OPA_W'(r_last_deriv);
            OPA_DEL: w_opa = OPA_W'(r_delta);
            OPA_ERR: w_opa = OPA_W'(r_err);
            OPA_LT:  w_opa = OPA_W'(r_lt);
            default: w_opa = '0;
        endcase
    end

    assign w_ma = i_ctl.a_hi ? w_opa[OPA_W-1:Q_FRAC]
                             : {{(MA_W-Q_FRAC){1'b0}}, w_opa[Q_FRAC-1:0]};

    always_comb begin
        case (i_ctl.b_sel)
            OPB_W:    w_mb = MB_W'(i_coef.setpoint_weight);
            OPB_DW:   w_mb = DW_B;
            OPB_POLE: w_mb = MB_W'(i_coef.deriv_pole);
            OPB_KD:   w_mb = MB_W'(i_coef.deriv_gain);
            OPB_KP:   w_mb = MB_W'(i_coef.prop_gain);
            OPB_KI:   w_mb = MB_W'(i_coef.integ_gain);
            OPB_KAW:  w_mb = MB_W'(i_coef.antiwindup_gain);
            default:  w_mb = '0;
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_term = r_prod_hi ? r_prod[ACC_W-1:0]
                              : ACC_W'($signed(r_prod[PROD_W-1:Q_FRAC]));

    always_comb begin
        case (i_ctl.acc_init)
            INIT_ZERO:  w_init = '0;
            INIT_PVD:   w_init = ACC_W'(r_pvd);
            INIT_NPV:   w_init = ACC_W'(r_npv);
            INIT_TI:    w_init = ACC_W'(r_ti);
            INIT_INTEG: w_init = ACC_W'(r_integral);
            default:    w_init = '0;
        endcase
    end

    assign w_base = (i_ctl.acc_mode == ACC_INIT) ? w_init : r_acc;
    assign w_sum  = r_prod_neg ? (w_base - w_term) : (w_base + w_term);
    assign n_acc  = (i_ctl.acc_mode == ACC_HOLD) ? r_acc : w_sum;

    // lower limit first, then upper
    assign w_min = TOT_W'(i_coef.out_min);
    assign w_max = TOT_W'(i_coef.out_max);
    assign w_lo  = (r_total < w_min) ? w_min : r_total;
    assign w_lim = (w_lo > w_max) ? w_max : w_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls         <= '0;
            r_lm         <= '0;
            r_integral   <= '0;
            r_last_deriv <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_ls <= i_setpoint;
                r_lm <= i_measurement;
            end
            if (i_ctl.st_integ) begin
                r_integral <= f_sat_st(n_acc);
            end
            if (i_ctl.st_deriv) begin
                r_last_deriv <= f_sat_st(n_acc);
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sp  <= i_setpoint;
            r_spd <= DIF_W'(i_setpoint) - DIF_W'(r_ls);
            r_spv <= DIF_W'(i_setpoint) - DIF_W'(i_measurement);
            r_pvd <= DIF_W'(i_measurement) - DIF_W'(r_lm);
            r_npv <= -DIF_W'(i_measurement);
        end
        r_prod     <= w_prod;
        r_prod_hi  <= i_ctl.a_hi;
        r_prod_neg <= i_ctl.neg;
        r_acc      <= n_acc;
        r_ti       <= (ST_W+1)'(r_integral) + (ST_W+1)'(r_last_deriv);
        if (i_ctl.st_delta) begin
            r_delta <= n_acc[DEL_W-1:0];
        end
        if (i_ctl.st_err) begin
            r_err <= n_acc[ERR_W-1:0];
        end
        if (i_ctl.st_total) begin
            r_total <= n_acc[TOT_W-1:0];
        end
        if (i_ctl.lim_en) begin
            r_lim     <= w_lim[IN_W-1:0];
            r_limited <= (w_lim != r_total);
        end
        if (i_ctl.lt_en) begin
            r_lt <= LT_W'(r_lim) - LT_W'(r_total);
        end
        if (i_ctl.out_load) begin
            r_drive       <= r_lim;
            r_out_limited <= r_limited;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_limited   = r_out_limited;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while previous result pending");

    a_flag_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.lim_en |=> (r_limited || (TOT_W'(r_lim) == r_total)))
        else $error("clamp flag low but drive differs from sum");

    a_lim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.lim_en && (i_coef.out_min <= i_coef.out_max))
        |=> ((r_lim >= i_coef.out_min) && (r_lim <= i_coef.out_max)))
        else $error("clamped drive outside configured limits");

endmodule

// File: rtl/pid_filtered_derivative_antiwindup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup_top
// PID controller with setpoint weighting, filtered derivative, output clamp
// and back-calculation anti-windup on one shared multiply accumulate unit.
// ----------------------------------------------------------------------------
// requests are processed one at a time: the 14 partial products pass one by
// one through the single 28x33 multiplier plus its stores, and a new request
// is taken only while idle or as the result loads into a free output slot
// reset: integrator, filtered derivative and previous samples clear to zero,
// coefficients and limits load their defaults, no result is pending
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_top #(
    parameter int unsigned DERIV_SP_WEIGHT = pidfd_pkg::DERIV_SP_WEIGHT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pidfd_in_if.sink      i_in,
    pidfd_out_if.source   o_out,
    pidfd_cfg_if.sink     i_cfg
);
    import pidfd_pkg::*;

    t_coef w_coef;
    t_ctl  w_ctl;
    logic  w_out_valid;
    logic  w_out_free;

    assign w_out_free  = !w_out_valid || o_out.ready;
    assign o_out.valid = w_out_valid;

    pidfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_coef  (w_coef)
    );

    pidfd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (w_out_free),
        .o_in_ready (i_in.ready),
        .o_ctl      (w_ctl)
    );

    pidfd_dp #(
        .DERIV_SP_WEIGHT (DERIV_SP_WEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_coef        (w_coef),
        .i_setpoint    (i_in.setpoint),
        .i_measurement (i_in.measurement),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (w_out_valid),
        .o_drive       (o_out.drive),
        .o_limited     (o_out.limited)
    );

endmodule
